// ----- sv/ibst_pkg.sv -----
// Shared types, opcodes and defaults for the implicit search tree block.
// No dependencies; the node store, the walker and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package ibst_pkg;

  localparam int unsigned LEVELS_DEF    = 4;
  localparam int unsigned KEY_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned INDEX_W       = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [INDEX_W-1:0]        node_index;
    logic signed [FIELD_W-1:0] node_value;
    logic signed [FIELD_W-1:0] search_key;
  } req_t;

  typedef struct packed {
    logic                      found;
    logic                      has_pred;
    logic signed [FIELD_W-1:0] pred_value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/ibst_chan_if.sv -----
// Valid/ready channel carrying one payload struct.
// Payload type is given by the instantiating scope (ibst_pkg::req_t or rsp_t).
`timescale 1ns / 1ps
`default_nettype none

interface ibst_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/ibst_node_mem.sv -----
// Node store: one write port, one read port, registered read data.
// Depends on ibst_pkg only for its parameter defaults.
`timescale 1ns / 1ps
`default_nettype none

module ibst_node_mem import ibst_pkg::*; #(
  parameter int unsigned ADDR_W = LEVELS_DEF,
  parameter int unsigned DATA_W = KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/ibst_walker.sv -----
// Descent sequencer: issues node reads level by level, tracks the running
// predecessor candidate and, on a match at an inner node, finishes with a right-spine read. Uses ibst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibst_walker import ibst_pkg::*; #(
  parameter int unsigned LEVELS    = LEVELS_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  req_t                 req_data_i,
  output logic                 req_ready_o,
  input  logic                 slot_free_i,
  output logic                 push_o,
  output rsp_t                 res_o,
  output logic                 wr_en_o,
  output logic [LEVELS-1:0]    wr_addr_o,
  output logic [KEY_WIDTH-1:0] wr_data_o,
  output logic                 rd_en_o,
  output logic [LEVELS-1:0]    rd_addr_o,
  input  logic [KEY_WIDTH-1:0] rd_data_i
);

  localparam int unsigned AW    = LEVELS;
  localparam int unsigned LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned IW    = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int unsigned NODES = (2 ** LEVELS) - 1;

  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);
  localparam logic [LW-1:0] LVL_PRE  = LW'(LEVELS - 2);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DESC  = 2'd1;
  localparam logic [1:0] S_RIGHT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic signed [KEY_WIDTH-1:0] cand_q, cand_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic [LW-1:0]               lvl_q, lvl_d;
  logic                        has_q, has_d;
  logic                        found_q, found_d;

  logic                        accept;
  logic [IW-1:0]               idx_ext;
  logic                        idx_ok;
  logic [KEY_WIDTH-1:0]        wkey;
  logic [KEY_WIDTH-1:0]        qkey;
  logic signed [KEY_WIDTH-1:0] node;
  logic                        eq;
  logic                        lt;
  logic [LW-1:0]               spine_shift;
  logic [AW-1:0]               spine_addr;
  logic [FIELD_W-1:0]          pred_ext;

  if (KEY_WIDTH <= FIELD_W) begin : g_narrow
    assign wkey     = req_data_i.node_value[KEY_WIDTH-1:0];
    assign qkey     = req_data_i.search_key[KEY_WIDTH-1:0];
    assign pred_ext = FIELD_W'(cand_q);
  end else begin : g_wide
    assign wkey     = KEY_WIDTH'($unsigned(req_data_i.node_value));
    assign qkey     = KEY_WIDTH'($unsigned(req_data_i.search_key));
    assign pred_ext = cand_q[FIELD_W-1:0];
  end

  assign accept      = req_valid_i && (state_q == S_IDLE);
  assign req_ready_o = (state_q == S_IDLE);

  assign idx_ext   = IW'(req_data_i.node_index);
  assign idx_ok    = (idx_ext != '0) && (idx_ext <= IW'(NODES));
  assign wr_en_o   = accept && (req_data_i.op == OP_WRITE) && idx_ok;
  assign wr_addr_o = idx_ext[AW-1:0];
  assign wr_data_o = wkey;

  assign node = rd_data_i;
  assign eq   = (node == key_q);
  assign lt   = (node < key_q);

  assign spine_shift = LVL_PRE - lvl_q;
  assign spine_addr  = (((pos_q << 1) | AW'(1)) << spine_shift) - AW'(1);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    cand_d    = cand_q;
    pos_d     = pos_q;
    lvl_d     = lvl_q;
    has_d     = has_q;
    found_d   = found_q;
    rd_en_o   = 1'b0;
    rd_addr_o = pos_q;
    push_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_data_i.op == OP_QUERY)) begin
          key_d     = qkey;
          cand_d    = '0;
          pos_d     = AW'(1);
          lvl_d     = '0;
          has_d     = 1'b0;
          found_d   = 1'b0;
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(1);
          state_d   = S_DESC;
        end
      end
      S_DESC: begin
        if (eq) begin
          found_d = 1'b1;
          if (lvl_q != LVL_LAST) begin
            rd_en_o   = 1'b1;
            rd_addr_o = spine_addr;
            state_d   = S_RIGHT;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          if (lt) begin
            has_d  = 1'b1;
            cand_d = node;
          end
          if (lvl_q == LVL_LAST) begin
            state_d = S_DONE;
          end else begin
            pos_d     = (pos_q << 1) | AW'(lt);
            lvl_d     = lvl_q + LW'(1);
            rd_en_o   = 1'b1;
            rd_addr_o = (pos_q << 1) | AW'(lt);
          end
        end
      end
      S_RIGHT: begin
        has_d   = 1'b1;
        cand_d  = node;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found      = found_q;
  assign res_o.has_pred   = has_q;
  assign res_o.pred_value = has_q ? pred_ext : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    cand_q  <= cand_d;
    pos_q   <= pos_d;
    lvl_q   <= lvl_d;
    has_q   <= has_d;
    found_q <= found_d;
  end

`ifndef SYNTHESIS
  a_pos_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DESC) |-> ((pos_q >> lvl_q) == AW'(1)))
    else $error("node slot does not match tree depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !rd_en_o)
    else $error("node write overlaps a node read");

  a_spine_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RIGHT) |-> (found_q && $past(state_q) == S_DESC))
    else $error("spine read without a matching node");

  a_root_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_data_i.op == OP_QUERY)) |=> (pos_q == AW'(1) && lvl_q == '0))
    else $error("query did not start at the root");

  a_push_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (slot_free_i && state_q == S_DONE))
    else $error("result pushed into a full output stage");
`endif

endmodule

`default_nettype wire

// ----- sv/implicit_bst_search_predecessor.sv -----
// Top level: node store, descent sequencer and the output stage.
// Depends on ibst_pkg, ibst_chan_if, ibst_node_mem and ibst_walker.
//
//   channel  dir  payload  carries
//   req      in   req_t    node write (op=0) or key query (op=1)
//   rsp      out  rsp_t    found, has_pred, pred_value; one per query
//
// A node write gives no response.
// A query reads one node per level, or stops early on a match at an inner node
// and then reads the last node of that node's left-subtree spine; the sequencer
// then hands the response to the output stage, waiting while that stage is full,
// and takes no new request until it has done so.
// The node store has no reset; rst_ni clears the sequencer and output valid.
// A stalled response holds in the output stage while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module implicit_bst_search_predecessor import ibst_pkg::*; #(
  parameter int unsigned LEVELS    = LEVELS_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ibst_chan_if.sink    req,
  ibst_chan_if.source  rsp
);

  logic                 slot_free;
  logic                 push;
  rsp_t                 res;
  logic                 wr_en;
  logic [LEVELS-1:0]    wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [LEVELS-1:0]    rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 out_valid_q;
  rsp_t                 out_data_q;

  ibst_node_mem #(
    .ADDR_W (LEVELS),
    .DATA_W (KEY_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ibst_walker #(
    .LEVELS    (LEVELS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_data_i  (req.data),
    .req_ready_o (req.ready),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  assign slot_free = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= res;
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_data_q;

endmodule

`default_nettype wire
